// ----- hw/rtl/svptw_pkg.sv -----
package svptw_pkg;

  // field widths
  localparam int unsigned XLEN       = 64;
  localparam int unsigned PPN_W      = 44;
  localparam int unsigned PADDR_W    = 56;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned VPN_W      = 9;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned CAUSE_W    = 3;
  localparam int unsigned ACC_W      = 2;
  localparam int unsigned PRIV_W     = 2;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned CFG_IDX_W  = 1;

  // queue between the classifier and the walker
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATION_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE_PAGE  = 1'd1;

  // translation mode that enables sv39
  localparam logic [MODE_W-1:0] MODE_SV39 = 4'd8;

  // access types
  localparam logic [ACC_W-1:0] ACC_FETCH = 2'd0;
  localparam logic [ACC_W-1:0] ACC_LOAD  = 2'd1;
  localparam logic [ACC_W-1:0] ACC_STORE = 2'd2;

  // privilege levels
  localparam logic [PRIV_W-1:0] PRIV_USER    = 2'd0;
  localparam logic [PRIV_W-1:0] PRIV_MACHINE = 2'd3;

  // fault causes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE         = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_MISALIGN_BASE = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_PF_BASE      = 3'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_WALK_BUS_ERR = 3'd5;

  // result kinds
  localparam logic RK_PTE_READ = 1'b0;
  localparam logic RK_DONE     = 1'b1;

  // input kinds
  localparam logic KIND_REQUEST  = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  // walk levels
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = 2'd2;

  // pte bit positions
  localparam int unsigned PTE_V   = 0;
  localparam int unsigned PTE_R   = 1;
  localparam int unsigned PTE_W   = 2;
  localparam int unsigned PTE_X   = 3;
  localparam int unsigned PTE_U   = 4;
  localparam int unsigned PTE_A   = 6;
  localparam int unsigned PTE_D   = 7;
  localparam int unsigned PTE_PPN = 10;

  typedef struct packed {
    logic               kind;
    logic [XLEN-1:0]    virtual_address;
    logic [ACC_W-1:0]   access_type;
    logic [1:0]         size_log2;
    logic [PRIV_W-1:0]  privilege;
    logic [XLEN-1:0]    pte_data;
    logic               bus_error;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [XLEN-1:0]    address;
    logic [CAUSE_W-1:0] fault_cause;
    logic [XLEN-1:0]    trap_value;
  } out_item_t;

  // what the walker must do with a queued transaction
  typedef enum logic [1:0] {
    OP_FAULT,
    OP_PASS,
    OP_WALK,
    OP_RESP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CAUSE_W-1:0] cause;
    logic [ACC_W-1:0]   acc;
    logic [PRIV_W-1:0]  priv;
    logic [XLEN-1:0]    data;
    logic               bus_error;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- hw/rtl/svptw_front.sv -----
module svptw_front (
  input  svptw_pkg::in_item_t         item,
  input  logic [svptw_pkg::MODE_W-1:0] translation_mode,
  output svptw_pkg::work_t            work
);
  import svptw_pkg::*;

  logic [ACC_W-1:0] acc;
  logic             misaligned;
  logic             canonical;
  logic             bypass;

  // anything that is not fetch or store counts as a load
  assign acc = (item.access_type == ACC_FETCH || item.access_type == ACC_STORE) ?
               item.access_type : ACC_LOAD;

  // alignment check
  always_comb begin
    if (acc == ACC_FETCH) begin
      misaligned = item.virtual_address[0];
    end else begin
      case (item.size_log2)
        2'd0:    misaligned = 1'b0;
        2'd1:    misaligned = item.virtual_address[0];
        2'd2:    misaligned = |item.virtual_address[1:0];
        2'd3:    misaligned = |item.virtual_address[2:0];
        default: misaligned = 1'b0;
      endcase
    end
  end

  // upper bits must all match bit 38
  assign canonical = (&item.virtual_address[63:38]) || !(|item.virtual_address[63:38]);
  assign bypass    = (item.privilege == PRIV_MACHINE) || (translation_mode != MODE_SV39);

  // classify the transaction
  always_comb begin
    work.acc       = acc;
    work.priv      = item.privilege;
    work.bus_error = item.bus_error;
    work.cause     = CAUSE_NONE;
    work.data      = item.virtual_address;
    if (item.kind == KIND_RESPONSE) begin
      work.op   = OP_RESP;
      work.data = item.pte_data;
    end else if (misaligned) begin
      work.op    = OP_FAULT;
      work.cause = CAUSE_W'(CAUSE_MISALIGN_BASE + CAUSE_W'(acc));
    end else if (bypass) begin
      work.op = OP_PASS;
    end else if (!canonical) begin
      work.op    = OP_FAULT;
      work.cause = CAUSE_W'(CAUSE_PF_BASE + CAUSE_W'(acc));
    end else begin
      work.op = OP_WALK;
    end
  end

endmodule

// ----- hw/rtl/svptw_queue.sv -----
module svptw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  svptw_pkg::work_t     push_data,
  input  logic                 pop,
  output svptw_pkg::work_t     head,
  output svptw_pkg::q_status_t status
);
  import svptw_pkg::*;

  work_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full && !pop |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

// ----- hw/rtl/svptw_back.sv -----
module svptw_back (
  input  logic                          clk,
  input  logic                          rst,
  input  svptw_pkg::work_t              head,
  input  svptw_pkg::q_status_t          q_status,
  input  logic [svptw_pkg::PPN_W-1:0]   root_table_page,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output svptw_pkg::out_item_t          out_item
);
  import svptw_pkg::*;

  // walk state
  logic                 walk_active;
  logic [LEVEL_W-1:0]   walk_level;
  logic [XLEN-1:0]      saved_vaddr;
  logic [ACC_W-1:0]     saved_access;
  logic [PRIV_W-1:0]    saved_privilege;
  logic [PADDR_W-1:0]   pending_entry_addr;

  logic                 walk_active_next;
  logic [LEVEL_W-1:0]   walk_level_next;
  logic [PADDR_W-1:0]   pending_entry_addr_next;
  logic                 res_valid;
  out_item_t            res;

  logic [XLEN-1:0]      pte;
  logic [PPN_W-1:0]     ppn;
  logic [CAUSE_W-1:0]   pf_cause;
  logic                 is_leaf;
  logic                 perm_ok;
  logic                 super_misaligned;
  logic [PADDR_W-1:0]   leaf_pa;
  logic [LEVEL_W-1:0]   lower_level;

  // entry address for one level of the walk
  function automatic logic [PADDR_W-1:0] entry_addr(input logic [PPN_W-1:0] base_ppn,
                                                    input logic [XLEN-1:0] va,
                                                    input logic [LEVEL_W-1:0] lvl);
    logic [VPN_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[20:12];
      2'd1:    idx = va[29:21];
      default: idx = va[38:30];
    endcase
    entry_addr = {base_ppn, idx, 3'b000};
  endfunction

  // output register is free or being emptied
  assign pop = !q_status.empty && (!out_valid || !out_stall);

  assign pte         = head.data;
  assign ppn         = pte[PTE_PPN +: PPN_W];
  assign pf_cause    = CAUSE_W'(CAUSE_PF_BASE + CAUSE_W'(saved_access));
  assign is_leaf     = pte[PTE_R] || pte[PTE_W] || pte[PTE_X];
  assign lower_level = LEVEL_W'(walk_level - 1'b1);

  // leaf permission
  always_comb begin
    case (saved_access)
      ACC_FETCH: perm_ok = pte[PTE_X];
      ACC_STORE: perm_ok = pte[PTE_W] && pte[PTE_D];
      default:   perm_ok = pte[PTE_R];
    endcase
  end

  // superpage alignment and physical address
  always_comb begin
    case (walk_level)
      2'd0: begin
        super_misaligned = 1'b0;
        leaf_pa          = {ppn, saved_vaddr[11:0]};
      end
      2'd1: begin
        super_misaligned = |ppn[8:0];
        leaf_pa          = {ppn[PPN_W-1:9], saved_vaddr[20:0]};
      end
      default: begin
        super_misaligned = |ppn[17:0];
        leaf_pa          = {ppn[PPN_W-1:18], saved_vaddr[29:0]};
      end
    endcase
  end

  // walker step for the queue head
  always_comb begin
    walk_active_next        = walk_active;
    walk_level_next         = walk_level;
    pending_entry_addr_next = pending_entry_addr;
    res_valid               = 1'b0;
    res.result_kind         = RK_DONE;
    res.address             = '0;
    res.fault_cause         = CAUSE_NONE;
    res.trap_value          = '0;
    case (head.op)
      OP_FAULT: begin
        walk_active_next = 1'b0;
        res_valid        = 1'b1;
        res.fault_cause  = head.cause;
        res.trap_value   = head.data;
      end
      OP_PASS: begin
        walk_active_next = 1'b0;
        res_valid        = 1'b1;
        res.address      = head.data;
      end
      OP_WALK: begin
        walk_active_next        = 1'b1;
        walk_level_next         = LEVEL_TOP;
        pending_entry_addr_next = entry_addr(root_table_page, head.data, LEVEL_TOP);
        res_valid               = 1'b1;
        res.result_kind         = RK_PTE_READ;
        res.address             = XLEN'(pending_entry_addr_next);
      end
      OP_RESP: begin
        if (walk_active) begin
          res_valid = 1'b1;
          if (head.bus_error) begin
            walk_active_next = 1'b0;
            res.fault_cause  = CAUSE_WALK_BUS_ERR;
            res.trap_value   = XLEN'(pending_entry_addr);
          end else if (!pte[PTE_V] || (pte[PTE_W] && !pte[PTE_R])) begin
            walk_active_next = 1'b0;
            res.fault_cause  = pf_cause;
            res.trap_value   = saved_vaddr;
          end else if (is_leaf) begin
            walk_active_next = 1'b0;
            if (!perm_ok || (saved_privilege == PRIV_USER && !pte[PTE_U]) ||
                super_misaligned || !pte[PTE_A]) begin
              res.fault_cause = pf_cause;
              res.trap_value  = saved_vaddr;
            end else begin
              res.address = XLEN'(leaf_pa);
            end
          end else if (walk_level == '0) begin
            walk_active_next = 1'b0;
            res.fault_cause  = pf_cause;
            res.trap_value   = saved_vaddr;
          end else begin
            walk_level_next         = lower_level;
            pending_entry_addr_next = entry_addr(ppn, saved_vaddr, lower_level);
            res.result_kind         = RK_PTE_READ;
            res.address             = XLEN'(pending_entry_addr_next);
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // walk control state
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active <= 1'b0;
      walk_level  <= '0;
    end else if (pop) begin
      walk_active <= walk_active_next;
      walk_level  <= walk_level_next;
    end
  end

  // saved request and pending entry address
  always_ff @(posedge clk) begin
    if (pop) begin
      pending_entry_addr <= pending_entry_addr_next;
      if (head.op == OP_WALK) begin
        saved_vaddr     <= head.data;
        saved_access    <= head.acc;
        saved_privilege <= head.priv;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_item <= res;
    end
  end

`ifndef SYNTHESIS
  a_walk_starts: assert property (@(posedge clk) disable iff (rst)
    pop && head.op == OP_WALK |=> walk_active && walk_level == LEVEL_TOP)
    else $error("walk did not start at top level");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    walk_active |-> walk_level <= LEVEL_TOP)
    else $error("walk level out of range");

  a_read_no_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_kind == RK_PTE_READ |->
      out_item.fault_cause == CAUSE_NONE && walk_active)
    else $error("entry read without an active walk");

  a_clean_tval: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.fault_cause == CAUSE_NONE |-> out_item.trap_value == '0)
    else $error("trap value set without fault");
`endif

endmodule

// ----- hw/rtl/sv39_page_table_walker_top.sv -----
// sv39 page table walker
// input channel (in_valid / in_stall / in_item) carries two kinds of
// transaction: a new translation request, or the page table entry returned
// for an earlier read request. output channel (out_valid / out_stall /
// out_item) carries one result per transaction: either an entry read request
// for the memory side or a finished translation with fault cause and trap value.
// a response that arrives with no walk in progress gives no result.
// configuration: cfg_valid / cfg_ready / cfg_index / cfg_data, index 0 is the
// translation mode, index 1 the root table page number; cfg_ready is always high.
// an accepted transaction is registered in the queue, then in the output register.
// throughput: one transaction per cycle while out_stall is low; the walker
// handles the queue head combinationally, so the output register is the only pacing point.
// a two-entry queue sits between the classifier and the walker; in_stall is
// high only while that queue is full, so input is accepted while a result
// still waits on a stalled output.
// reset clears the queue, the walk, the output valid and both config registers.
module sv39_page_table_walker_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  svptw_pkg::in_item_t               in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output svptw_pkg::out_item_t              out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svptw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [svptw_pkg::XLEN-1:0]        cfg_data
);
  import svptw_pkg::*;

  logic [MODE_W-1:0] translation_mode;
  logic [PPN_W-1:0]  root_table_page;
  work_t             work;
  work_t             head;
  q_status_t         q_status;
  logic              push;
  logic              pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      translation_mode <= '0;
      root_table_page  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRANSLATION_MODE: translation_mode <= cfg_data[MODE_W-1:0];
        CFG_ROOT_TABLE_PAGE:  root_table_page  <= cfg_data[PPN_W-1:0];
        default:              translation_mode <= translation_mode;
      endcase
    end
  end

  // input handshake
  assign in_stall = q_status.full;
  assign push     = in_valid && !in_stall;

  svptw_front u_front (
    .item             (in_item),
    .translation_mode (translation_mode),
    .work             (work)
  );

  svptw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (work),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  svptw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_status        (q_status),
    .root_table_page (root_table_page),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item)
  );

endmodule

// ----- test/sv39_page_table_walker_top_test.sv -----
`timescale 1ns / 100ps

module sv39_page_table_walker_top_test;
  import svptw_pkg::*;

  // codes the package leaves unnamed
  localparam logic [ACC_W-1:0]  ACC_SPARE       = 2'd3;
  localparam logic [PRIV_W-1:0] PRIV_SUPERVISOR = 2'd1;
  localparam logic [PRIV_W-1:0] PRIV_RESERVED   = 2'd2;
  localparam int unsigned       HOLD_CYCLES     = 60;
  localparam int unsigned       SETTLE_CYCLES   = 4;
  localparam int unsigned       MAX_LINES       = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [XLEN-1:0]      cfg_data = '0;

  // transactions waiting to be offered, translations still owed by the block
  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        items_queued = 0;
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      hold_on = 1'b0;
  event      stall_results_go;

  // shadow of the configuration and of the walk in progress
  logic [MODE_W-1:0]  mode_reg = '0;
  logic [PPN_W-1:0]   root_ppn = '0;
  logic               walking = 1'b0;
  logic [LEVEL_W-1:0] walk_lvl = '0;
  logic [XLEN-1:0]    walk_va = '0;
  logic [ACC_W-1:0]   walk_acc = '0;
  logic [PRIV_W-1:0]  walk_priv = '0;
  logic [PADDR_W-1:0] walk_pte_addr = '0;

  sv39_page_table_walker_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [XLEN-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_LINES) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // address of the entry for one level of the walk
  function automatic logic [PADDR_W-1:0] pte_slot(input logic [PPN_W-1:0] table_ppn,
                                                  input logic [XLEN-1:0] va,
                                                  input int unsigned lvl);
    logic [VPN_W-1:0] vpn;
    vpn = va[PAGE_SHIFT + VPN_W * lvl +: VPN_W];
    return {table_ppn, vpn, 3'b000};
  endfunction

  task automatic expect_result(input logic rk, input logic [XLEN-1:0] addr,
                               input logic [CAUSE_W-1:0] cause, input logic [XLEN-1:0] tval);
    out_item_t r;
    r.result_kind = rk;
    r.address     = addr;
    r.fault_cause = cause;
    r.trap_value  = tval;
    expected_results.push_back(r);
  endtask

  task automatic expect_fault(input logic [CAUSE_W-1:0] cause, input logic [XLEN-1:0] tval);
    walking = 1'b0;
    expect_result(RK_DONE, '0, cause, tval);
  endtask

  // expected outcome of one accepted transaction
  task automatic predict_translation(input in_item_t it);
    logic [XLEN-1:0]    va, amask, pte, lowmask, pa;
    logic [PPN_W-1:0]   ppn;
    logic [ACC_W-1:0]   acc;
    logic [CAUSE_W-1:0] pf;
    int unsigned        lvl;
    logic               allowed;
    if (it.kind == KIND_REQUEST) begin
      va = it.virtual_address;
      acc = (it.access_type == ACC_FETCH || it.access_type == ACC_STORE) ?
            it.access_type : ACC_LOAD;
      amask = (acc == ACC_FETCH) ? 64'd1 : ((64'd1 << it.size_log2) - 64'd1);
      walking = 1'b0;
      if ((va & amask) != 0) begin
        expect_fault(CAUSE_MISALIGN_BASE + acc, va);
      end else if (it.privilege == PRIV_MACHINE || mode_reg != MODE_SV39) begin
        expect_result(RK_DONE, va, CAUSE_NONE, '0);
      end else if (va[XLEN-1:38] != '0 && va[XLEN-1:38] != '1) begin
        expect_fault(CAUSE_PF_BASE + acc, va);
      end else begin
        walk_va = va;
        walk_acc = acc;
        walk_priv = it.privilege;
        walk_lvl = LEVEL_TOP;
        walk_pte_addr = pte_slot(root_ppn, va, LEVEL_TOP);
        walking = 1'b1;
        expect_result(RK_PTE_READ, 64'(walk_pte_addr), CAUSE_NONE, '0);
      end
    end else if (walking) begin
      pte = it.pte_data;
      ppn = pte[PTE_PPN +: PPN_W];
      lvl = walk_lvl;
      va = walk_va;
      pf = CAUSE_PF_BASE + walk_acc;
      if (it.bus_error) begin
        expect_fault(CAUSE_WALK_BUS_ERR, 64'(walk_pte_addr));
      end else if (!pte[PTE_V] || (pte[PTE_W] && !pte[PTE_R])) begin
        expect_fault(pf, va);
      end else if (pte[PTE_R] || pte[PTE_W] || pte[PTE_X]) begin
        // leaf entry
        case (walk_acc)
          ACC_FETCH: allowed = pte[PTE_X];
          ACC_STORE: allowed = pte[PTE_W];
          default:   allowed = pte[PTE_R];
        endcase
        if (lvl > 2) lvl = 2;
        lowmask = (64'd1 << (VPN_W * lvl)) - 64'd1;
        if (!allowed || (walk_priv == PRIV_USER && !pte[PTE_U])) begin
          expect_fault(pf, va);
        end else if ((64'(ppn) & lowmask) != 0) begin
          expect_fault(pf, va);
        end else if (!pte[PTE_A] || (walk_acc == ACC_STORE && !pte[PTE_D])) begin
          expect_fault(pf, va);
        end else begin
          lowmask = lowmask << PAGE_SHIFT;
          pa = ((64'(ppn) << PAGE_SHIFT) & ~lowmask) | (va & lowmask) | (va & 64'hFFF);
          walking = 1'b0;
          expect_result(RK_DONE, pa & ((64'd1 << PADDR_W) - 64'd1), CAUSE_NONE, '0);
        end
      end else if (lvl == 0) begin
        expect_fault(pf, va);
      end else begin
        // pointer to the next level
        walk_lvl = LEVEL_W'(lvl - 1);
        walk_pte_addr = pte_slot(ppn, va, walk_lvl);
        expect_result(RK_PTE_READ, 64'(walk_pte_addr), CAUSE_NONE, '0);
      end
    end
  endtask

  // stimulus builders, unused fields get random content
  task automatic push_request(input logic [XLEN-1:0] va, input logic [ACC_W-1:0] acc,
                              input logic [1:0] sz, input logic [PRIV_W-1:0] priv);
    in_item_t it;
    it.kind            = KIND_REQUEST;
    it.virtual_address = va;
    it.access_type     = acc;
    it.size_log2       = sz;
    it.privilege       = priv;
    it.pte_data        = rand64();
    it.bus_error       = 1'($urandom_range(1));
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_response(input logic [XLEN-1:0] pte, input logic err);
    in_item_t it;
    it.kind            = KIND_RESPONSE;
    it.virtual_address = rand64();
    it.access_type     = ACC_W'($urandom_range(3));
    it.size_log2       = 2'($urandom_range(3));
    it.privilege       = PRIV_W'($urandom_range(3));
    it.pte_data        = pte;
    it.bus_error       = err;
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic logic [XLEN-1:0] branch_entry();
    logic [XLEN-1:0] pte;
    pte = rand64();
    pte[PTE_V] = 1'b1;
    pte[PTE_R] = 1'b0;
    pte[PTE_W] = 1'b0;
    pte[PTE_X] = 1'b0;
    return pte;
  endfunction

  // leaf that grants the access at the given level
  function automatic logic [XLEN-1:0] leaf_entry(input logic [ACC_W-1:0] acc,
                                                 input logic [PRIV_W-1:0] priv,
                                                 input int unsigned lvl);
    logic [XLEN-1:0] pte;
    pte = rand64();
    pte[PTE_V] = 1'b1;
    case (acc)
      ACC_FETCH: pte[PTE_X] = 1'b1;
      ACC_STORE: begin
        pte[PTE_W] = 1'b1;
        pte[PTE_D] = 1'b1;
      end
      default:   pte[PTE_R] = 1'b1;
    endcase
    if (pte[PTE_W]) pte[PTE_R] = 1'b1;
    if (priv == PRIV_USER) pte[PTE_U] = 1'b1;
    pte[PTE_A] = 1'b1;
    if (lvl > 0) pte[PTE_PPN +: VPN_W] = '0;
    if (lvl > 1) pte[PTE_PPN + VPN_W +: VPN_W] = '0;
    return pte;
  endfunction

  // one request and the entries of its walk, optionally with one bad entry
  task automatic queue_walk(input bit damaged);
    logic [XLEN-1:0]   va;
    logic [XLEN-1:0]   entry [0:2];
    logic              err [0:2];
    logic [ACC_W-1:0]  acc;
    logic [1:0]        sz;
    logic [PRIV_W-1:0] priv;
    int                pick, leaf_lvl, depth, cut;
    acc = ACC_W'($urandom_range(3));
    sz = 2'($urandom_range(3));
    pick = $urandom_range(9);
    priv = (pick < 4) ? PRIV_USER : ((pick < 8) ? PRIV_SUPERVISOR : PRIV_RESERVED);
    va = rand64();
    va[XLEN-1:39] = {25{va[38]}};
    if (acc == ACC_FETCH) va[0] = 1'b0;
    else va = va & ~((64'd1 << sz) - 64'd1);
    pick = $urandom_range(99);
    leaf_lvl = (pick < 60) ? 0 : ((pick < 85) ? 1 : 2);
    depth = 3 - leaf_lvl;
    for (int i = 0; i < depth; i++) begin
      entry[i] = (i == depth - 1) ? leaf_entry(acc, priv, leaf_lvl) : branch_entry();
      err[i] = 1'b0;
    end
    cut = depth - 1;
    if (damaged) begin
      cut = $urandom_range(depth - 1);
      case ($urandom_range(8))
        0: err[cut] = 1'b1;
        1: entry[cut][PTE_V] = 1'b0;
        2: begin
          entry[cut][PTE_W] = 1'b1;
          entry[cut][PTE_R] = 1'b0;
        end
        3: entry[cut][PTE_R +: 3] = 3'($urandom_range(7));
        4: entry[cut][PTE_U] = 1'b0;
        5: entry[cut][PTE_A] = 1'b0;
        6: entry[cut][PTE_D] = 1'b0;
        7: entry[cut][PTE_PPN] = 1'b1;
        default: begin
          entry[cut] = rand64();
          err[cut] = 1'($urandom_range(1));
        end
      endcase
      // sometimes the rest of the walk still arrives
      if ($urandom_range(1)) cut = depth - 1;
    end
    push_request(va, acc, sz, priv);
    for (int i = 0; i <= cut; i++) push_response(entry[i], err[i]);
  endtask

  task automatic fill_random(input int n);
    int goal, pick;
    goal = items_queued + n;
    while (items_queued < goal) begin
      pick = $urandom_range(99);
      if (pick < 65) queue_walk(1'b0);
      else if (pick < 82) queue_walk(1'b1);
      else if (pick < 90)
        push_request(rand64(), ACC_W'($urandom_range(3)), 2'($urandom_range(3)),
                     PRIV_W'($urandom_range(3)));
      else if (pick < 95) push_response(rand64(), 1'($urandom_range(1)));
      else push_request(rand64(), ACC_W'($urandom_range(3)), 2'($urandom_range(3)),
                        PRIV_MACHINE);
    end
  endtask

  // sender pauses until every owed result is back
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [XLEN-1:0] value);
    logic [XLEN-1:0] data;
    data = rand64();
    if (idx == CFG_TRANSLATION_MODE) data[MODE_W-1:0] = value[MODE_W-1:0];
    else data[PPN_W-1:0] = value[PPN_W-1:0];
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // input driver, predicts each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TRANSLATION_MODE: mode_reg = cfg_data[MODE_W-1:0];
          CFG_ROOT_TABLE_PAGE:  root_ppn = cfg_data[PPN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_translation(in_item);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall, random or held
  always @(posedge clk) begin
    if (hold_on) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // long stretch of back pressure
  initial begin
    forever begin
      @(stall_results_go);
      @(posedge clk);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %p", out_item));
      end else begin
        want = expected_results.pop_front();
        if (out_item.result_kind !== want.result_kind)
          flag_mismatch($sformatf("result_kind got %b want %b",
                                  out_item.result_kind, want.result_kind));
        if (out_item.address !== want.address)
          flag_mismatch($sformatf("address got %h want %h", out_item.address, want.address));
        if (out_item.fault_cause !== want.fault_cause)
          flag_mismatch($sformatf("fault_cause got %0d want %0d",
                                  out_item.fault_cause, want.fault_cause));
        if (out_item.trap_value !== want.trap_value)
          flag_mismatch($sformatf("trap_value got %h want %h",
                                  out_item.trap_value, want.trap_value));
      end
    end
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // translation off after reset: alignment checks and pass-through
    push_request(64'hFFFF_FFFF_FFFF_FFFF, ACC_FETCH, 2'd0, PRIV_USER);
    push_request(64'h8, ACC_LOAD, 2'd3, PRIV_USER);
    push_request(64'h1, ACC_STORE, 2'd1, PRIV_SUPERVISOR);
    push_request(64'h2, ACC_SPARE, 2'd2, PRIV_RESERVED);
    push_response('1, 1'b1);
    wait_until_idle();
    write_register(CFG_TRANSLATION_MODE, MODE_SV39);
    write_register(CFG_ROOT_TABLE_PAGE, '1);
    @(negedge clk);

    // machine mode, non-canonical address, entry bus error
    push_request(64'h0, ACC_FETCH, 2'd0, PRIV_MACHINE);
    push_request(64'h0000_0080_0000_0000, ACC_LOAD, 2'd0, PRIV_SUPERVISOR);
    push_request(64'hFFFF_FFFF_FFFF_F000, ACC_STORE, 2'd3, PRIV_RESERVED);
    push_response(rand64(), 1'b1);
    // pointer entry at the last level
    push_request(64'h0, ACC_FETCH, 2'd0, PRIV_USER);
    push_response(branch_entry(), 1'b0);
    push_response(branch_entry(), 1'b0);
    push_response(branch_entry(), 1'b0);
    // write-only leaf
    push_request(64'h0000_003F_FFFF_F000, ACC_LOAD, 2'd3, PRIV_SUPERVISOR);
    push_response(64'h45, 1'b0);
    // new request abandons the walk, then a gigapage
    push_request(64'h1000, ACC_STORE, 2'd2, PRIV_USER);
    push_request(64'hFFFF_FFC0_0000_0000, ACC_LOAD, 2'd0, PRIV_SUPERVISOR);
    push_response(leaf_entry(ACC_LOAD, PRIV_SUPERVISOR, 2), 1'b0);
    // access type three on a megapage
    push_request(64'h0000_0012_3456_7000, ACC_SPARE, 2'd3, PRIV_USER);
    push_response(branch_entry(), 1'b0);
    push_response(leaf_entry(ACC_SPARE, PRIV_USER, 1), 1'b0);
    // all-ones entry is a misaligned superpage
    push_request(64'h0000_0000_0000_0100, ACC_LOAD, 2'd2, PRIV_SUPERVISOR);
    push_response('1, 1'b0);
    // full walk to a page with the widest page number
    push_request(64'hFFFF_FFFF_FFFF_FFF8, ACC_STORE, 2'd3, PRIV_USER);
    push_response(branch_entry(), 1'b0);
    push_response(branch_entry(), 1'b0);
    push_response({10'h000, {PPN_W{1'b1}}, 10'h0D7}, 1'b0);
    wait_until_idle();

    // sender idles lightly, receiver heavily
    write_register(CFG_ROOT_TABLE_PAGE, rand64());
    @(negedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 71;
    fill_random(300);
    wait_until_idle();
    fill_random(350);
    wait_until_idle();

    // the other way round
    write_register(CFG_ROOT_TABLE_PAGE, '0);
    @(negedge clk);
    send_idle_pct = 71;
    recv_idle_pct = 14;
    fill_random(320);
    wait_until_idle();
    fill_random(330);
    wait_until_idle();

    // no idling, with one long back pressure stretch
    write_register(CFG_ROOT_TABLE_PAGE, '1);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(300);
    -> stall_results_go;
    wait_until_idle();
    write_register(CFG_TRANSLATION_MODE, '1);
    @(negedge clk);
    fill_random(100);
    wait_until_idle();
    write_register(CFG_TRANSLATION_MODE, '0);
    @(negedge clk);
    fill_random(50);
    wait_until_idle();
    write_register(CFG_TRANSLATION_MODE, MODE_SV39);
    write_register(CFG_ROOT_TABLE_PAGE, rand64());
    @(negedge clk);
    fill_random(150);
    wait_until_idle();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/svptw_pkg.sv
hw/rtl/svptw_front.sv
hw/rtl/svptw_queue.sv
hw/rtl/svptw_back.sv
hw/rtl/sv39_page_table_walker_top.sv
test/sv39_page_table_walker_top_test.sv
